// ----- rtl/psg_pkg.sv -----
package psg_pkg;

    localparam int LEVEL_W     = 14;
    localparam int GAIN_W      = 9;
    localparam int SAMPLE_W    = 18;
    localparam int PERIOD_W    = 10;
    localparam int CNT_W       = 11;
    localparam int ATT_W       = 4;
    localparam int LFSR_W      = 16;
    localparam int NOISE_CTL_W = 4;
    localparam int NUM_TONES   = 3;
    localparam int NUM_CH      = 4;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 9'd128;
    localparam logic [GAIN_W-1:0]  GAIN_UNITY = 9'd256;
    localparam logic [LFSR_W-1:0]  LFSR_SEED  = 16'h8000;
    localparam logic [ATT_W-1:0]   ATT_SILENT = 4'hF;
    localparam logic [1:0]         CH_NOISE   = 2'd3;
    localparam logic [1:0]         CH_TONE2   = 2'd2;

    localparam logic signed [CNT_W-1:0] NOISE_RELOAD_16 = 11'sd16;
    localparam logic signed [CNT_W-1:0] NOISE_RELOAD_32 = 11'sd32;
    localparam logic signed [CNT_W-1:0] NOISE_RELOAD_64 = 11'sd64;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } psg_op_t;

    typedef enum logic [1:0] {
        NOISE_RATE_16    = 2'd0,
        NOISE_RATE_32    = 2'd1,
        NOISE_RATE_64    = 2'd2,
        NOISE_RATE_TONE2 = 2'd3
    } psg_noise_rate_t;

    // per-channel control handed to the mixer
    typedef struct packed {
        logic             on;
        logic             neg;
        logic [ATT_W-1:0] atten;
    } psg_term_t;

    // round(16384 * 10^(-(k+1)/10)), level fifteen is silent
    function automatic logic [LEVEL_W-1:0] att_level(input logic [ATT_W-1:0] k);
        logic [LEVEL_W-1:0] v;
        begin
            case (k)
                4'd0:    v = 14'd13014;
                4'd1:    v = 14'd10338;
                4'd2:    v = 14'd8211;
                4'd3:    v = 14'd6523;
                4'd4:    v = 14'd5181;
                4'd5:    v = 14'd4115;
                4'd6:    v = 14'd3269;
                4'd7:    v = 14'd2597;
                4'd8:    v = 14'd2063;
                4'd9:    v = 14'd1638;
                4'd10:   v = 14'd1301;
                4'd11:   v = 14'd1034;
                4'd12:   v = 14'd821;
                4'd13:   v = 14'd652;
                4'd14:   v = 14'd518;
                default: v = 14'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/psg_mixer.sv -----
module psg_mixer
(
    input  psg_pkg::psg_term_t                  term_ctl [psg_pkg::NUM_CH],
    input  logic [psg_pkg::GAIN_W-1:0]          gain     [psg_pkg::NUM_CH],
    output logic signed [psg_pkg::SAMPLE_W-1:0] sample
);

    import psg_pkg::*;

    localparam int MAG_W  = LEVEL_W + GAIN_W;
    localparam int TERM_W = MAG_W + 1 - 8;

    logic [GAIN_W-1:0]        g    [NUM_CH];
    logic [MAG_W-1:0]         mag  [NUM_CH];
    logic signed [MAG_W:0]    smag [NUM_CH];
    logic signed [TERM_W-1:0] term [NUM_CH];

    always_comb
    begin
        sample = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            g[i]    = (gain[i] > GAIN_UNITY) ? GAIN_UNITY : gain[i];
            mag[i]  = att_level(term_ctl[i].atten) * g[i];
            smag[i] = $signed({1'b0, mag[i]});
            if (term_ctl[i].neg)
            begin
                smag[i] = -smag[i];
            end
            // dropping the low byte floors toward minus infinity
            term[i] = smag[i][MAG_W:8];
            if (term_ctl[i].on)
            begin
                sample = sample + SAMPLE_W'(term[i]);
            end
        end
    end

endmodule

// ----- rtl/psg_tone_noise_generator_core.sv -----
// Three square-wave tone voices and one noise voice behind a latch/data
// register interface.
// Input stream: tuser selects the request kind (write byte or master clock
// tick), tdata carries the write byte. Gains are set on the cfg port (index
// 0..2 tone voices, 3 noise); the user must set them only while the block is
// idle, which the block itself does not enforce. Every TICKS_PER_STEP-th
// tick steps the enabled voices and pushes one mixed 18-bit sample on the
// output stream; writes and other ticks give none. Throughput: one request
// per cycle unless the output stalls. A stepping tick goes via the input
// register to the result register (counter update, four 14x9 products summed).
// Reset returns all voices to silence, periods and counters to zero, the
// noise shift register to 0x8000 and all gains to 128.
// When the output is stalled the result register holds its sample, the
// input register holds one further request and s_axis_tready falls; both
// sides move again in the cycle m_axis_tready returns.
module psg_tone_noise_generator_core
#(
    parameter int TICKS_PER_STEP = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [psg_pkg::GAIN_W-1:0]          cfg_wdata,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [psg_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] write_byte
    input  logic                                s_axis_tuser,  // [0] opcode
    // sample stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [psg_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // [17:0] sample, rest zero
);

    import psg_pkg::*;

    localparam int PRE_W = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
    localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS_PER_STEP - 1);

    // input register
    logic                 in_valid_reg;
    psg_op_t              in_op_reg;
    logic [IN_DATA_W-1:0] in_byte_reg;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    // chip state
    logic [GAIN_W-1:0]       gain_reg      [NUM_CH];
    logic [PERIOD_W-1:0]     period_reg    [NUM_TONES];
    logic [PERIOD_W-1:0]     period_next   [NUM_TONES];
    logic [ATT_W-1:0]        atten_reg     [NUM_CH];
    logic [ATT_W-1:0]        atten_next    [NUM_CH];
    logic signed [CNT_W-1:0] cnt_reg       [NUM_CH];
    logic signed [CNT_W-1:0] cnt_next      [NUM_CH];
    logic                    pol_reg       [NUM_CH];
    logic                    pol_next      [NUM_CH];
    logic [NOISE_CTL_W-1:0]  noise_ctl_reg, noise_ctl_next;
    logic [LFSR_W-1:0]       lfsr_reg,      lfsr_next;
    logic [1:0]              latch_ch_reg,  latch_ch_next;
    logic                    latch_tone_reg, latch_tone_next;
    logic [PRE_W-1:0]        pre_reg,       pre_next;

    // step candidates
    logic                    ch_on     [NUM_CH];
    logic signed [CNT_W-1:0] cnt_dec   [NUM_CH];
    logic                    wrap      [NUM_CH];
    logic signed [CNT_W-1:0] cnt_step  [NUM_CH];
    logic                    pol_step  [NUM_CH];
    logic signed [CNT_W-1:0] noise_reload;
    logic                    noise_fb;
    logic [LFSR_W-1:0]       lfsr_step;

    logic                    advance;
    logic                    is_tick;
    logic                    do_step;
    logic [1:0]              wr_ch;
    logic                    wr_tone;

    psg_term_t                  term_ctl [NUM_CH];
    logic signed [SAMPLE_W-1:0] mix_sample;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign is_tick       = (in_op_reg == OP_TICK);
    assign do_step       = advance && is_tick && (pre_reg == PRE_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= psg_op_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
    end

    // what every voice would do on a step
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            cnt_dec[i] = cnt_reg[i] - CNT_W'(1);
            wrap[i]    = (cnt_dec[i] <= 0);
            pol_step[i] = pol_reg[i] ^ wrap[i];
        end
        for (int i = 0; i < NUM_TONES; i++)
        begin
            ch_on[i]    = (period_reg[i] != '0);
            cnt_step[i] = wrap[i] ? $signed({1'b0, period_reg[i]}) : cnt_dec[i];
        end

        case (psg_noise_rate_t'(noise_ctl_reg[1:0]))
            NOISE_RATE_16: noise_reload = NOISE_RELOAD_16;
            NOISE_RATE_32: noise_reload = NOISE_RELOAD_32;
            NOISE_RATE_64: noise_reload = NOISE_RELOAD_64;
            default:       noise_reload = $signed({1'b0, period_reg[CH_TONE2]});
        endcase
        ch_on[CH_NOISE]    = (noise_ctl_reg != '0);
        cnt_step[CH_NOISE] = wrap[CH_NOISE] ? noise_reload : cnt_dec[CH_NOISE];

        // white noise taps bits 0 and 3, periodic noise recirculates bit 0
        noise_fb  = noise_ctl_reg[2] ? (lfsr_reg[0] ^ lfsr_reg[3]) : lfsr_reg[0];
        lfsr_step = (wrap[CH_NOISE] && !pol_step[CH_NOISE]) ?
                    {noise_fb, lfsr_reg[LFSR_W-1:1]} : lfsr_reg;

        for (int i = 0; i < NUM_TONES; i++)
        begin
            term_ctl[i].on    = ch_on[i];
            term_ctl[i].neg   = pol_step[i];
            term_ctl[i].atten = atten_reg[i];
        end
        term_ctl[CH_NOISE].on    = ch_on[CH_NOISE] && lfsr_step[0];
        term_ctl[CH_NOISE].neg   = 1'b0;
        term_ctl[CH_NOISE].atten = atten_reg[CH_NOISE];
    end

    psg_mixer u_mixer
    (
        .term_ctl (term_ctl),
        .gain     (gain_reg),
        .sample   (mix_sample)
    );

    // state update for the request in the input register
    always_comb
    begin
        period_next     = period_reg;
        atten_next      = atten_reg;
        cnt_next        = cnt_reg;
        pol_next        = pol_reg;
        noise_ctl_next  = noise_ctl_reg;
        lfsr_next       = lfsr_reg;
        latch_ch_next   = latch_ch_reg;
        latch_tone_next = latch_tone_reg;
        pre_next        = pre_reg;

        // a latch byte retargets before its nibble lands
        wr_ch   = in_byte_reg[7] ? in_byte_reg[6:5] : latch_ch_reg;
        wr_tone = in_byte_reg[7] ? !in_byte_reg[4] : latch_tone_reg;

        if (advance && !is_tick)
        begin
            latch_ch_next   = wr_ch;
            latch_tone_next = wr_tone;
            if (!wr_tone)
            begin
                atten_next[wr_ch] = in_byte_reg[ATT_W-1:0];
            end
            else if (wr_ch == CH_NOISE)
            begin
                noise_ctl_next = in_byte_reg[NOISE_CTL_W-1:0];
                lfsr_next      = LFSR_SEED;
            end
            else
            begin
                for (int i = 0; i < NUM_TONES; i++)
                begin
                    if (wr_ch == 2'(i))
                    begin
                        if (in_byte_reg[7])
                        begin
                            period_next[i][3:0] = in_byte_reg[3:0];
                        end
                        else
                        begin
                            period_next[i][PERIOD_W-1:4] = in_byte_reg[5:0];
                        end
                    end
                end
            end
        end

        if (advance && is_tick)
        begin
            pre_next = (pre_reg == PRE_LAST) ? '0 : pre_reg + PRE_W'(1);
        end

        if (do_step)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (ch_on[i])
                begin
                    cnt_next[i] = cnt_step[i];
                    pol_next[i] = pol_step[i];
                end
            end
            if (ch_on[CH_NOISE])
            begin
                lfsr_next = lfsr_step;
            end
        end

        out_valid_next = (out_valid_reg && !m_axis_tready) || do_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                gain_reg[i]  <= GAIN_RESET;
                atten_reg[i] <= ATT_SILENT;
                cnt_reg[i]   <= '0;
                pol_reg[i]   <= 1'b0;
            end
            for (int i = 0; i < NUM_TONES; i++)
            begin
                period_reg[i] <= '0;
            end
            noise_ctl_reg  <= '0;
            lfsr_reg       <= LFSR_SEED;
            latch_ch_reg   <= '0;
            latch_tone_reg <= 1'b1;
            pre_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg[cfg_index] <= cfg_wdata;
            end
            atten_reg      <= atten_next;
            cnt_reg        <= cnt_next;
            pol_reg        <= pol_next;
            period_reg     <= period_next;
            noise_ctl_reg  <= noise_ctl_next;
            lfsr_reg       <= lfsr_next;
            latch_ch_reg   <= latch_ch_next;
            latch_tone_reg <= latch_tone_next;
            pre_reg        <= pre_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            sample_reg <= mix_sample;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-SAMPLE_W){1'b0}}, sample_reg};

endmodule

// ----- rtl/psg_checker.sv -----
module psg_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [psg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import psg_pkg::*;

    // a stalled sample holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled sample changed or dropped");

    // with the result slot empty nothing can block the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request side blocked with empty result register");

    // a fresh sample comes from a tick that passed the input register and then the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK), 2))
        else $error("sample without a preceding tick request");

endmodule

bind psg_tone_noise_generator_core psg_checker u_psg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tb.sv -----
module tb;

    import psg_pkg::*;

    localparam int TICKS_PER_STEP = 16;
    localparam int RANDOM_ITEMS   = 480;
    localparam int RANDOM_STEPS   = 16;
    localparam int CYCLE_LIMIT    = 400000;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [1:0]              cfg_index     = '0;
    logic [GAIN_W-1:0]       cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;   // [7:0] write_byte
    logic                    s_axis_tuser  = 1'b0;  // [0] opcode
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;          // [17:0] sample, rest zero

    psg_tone_noise_generator_core #(
        .TICKS_PER_STEP (TICKS_PER_STEP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // chip state as seen by the scoreboard
    int unsigned        att_scale [16] = '{13014, 10338, 8211, 6523, 5181, 4115, 3269, 2597,
                                           2063, 1638, 1301, 1034, 821, 652, 518, 0};
    logic [GAIN_W-1:0]  gain_edges [7] = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd256, 9'd257, 9'd511};
    logic [GAIN_W-1:0]  gain [NUM_CH]        = '{default: GAIN_RESET};
    logic [PERIOD_W-1:0] period [NUM_TONES]  = '{default: '0};
    logic [ATT_W-1:0]   atten [NUM_CH]       = '{default: ATT_SILENT};
    int                 counter [NUM_CH]     = '{default: 0};
    bit                 polarity [NUM_CH]    = '{default: 1'b0};
    logic [NOISE_CTL_W-1:0] noise_ctl        = '0;
    logic [1:0]         latch_ch             = '0;
    bit                 latch_tone           = 1'b1;
    logic [LFSR_W-1:0]  lfsr                 = LFSR_SEED;
    int                 prescale             = 0;

    logic [SAMPLE_W-1:0] samples_due [$];
    int  errors          = 0;
    int  items_sent      = 0;
    int  steps_predicted = 0;
    int  cycle_count     = 0;
    int  hold_cycles     = 0;
    bit  tx_calm         = 1'b0;
    bit  rx_calm         = 1'b0;

    function automatic int scaled(input int unsigned lvl, input bit neg,
                                  input logic [GAIN_W-1:0] g);
        int mag;
        mag = lvl * ((g > GAIN_UNITY) ? GAIN_UNITY : g);
        // negative terms round toward minus infinity
        return neg ? ((-mag) >>> 8) : (mag >>> 8);
    endfunction

    function automatic void predict(input psg_op_t op, input logic [7:0] b);
        int acc;
        if (op == OP_WRITE) begin
            if (b[7]) begin
                latch_ch   = b[6:5];
                latch_tone = !b[4];
            end
            if (!latch_tone)
                atten[latch_ch] = b[3:0];
            else if (latch_ch == CH_NOISE) begin
                noise_ctl = b[3:0];
                lfsr      = LFSR_SEED;
            end
            else if (b[7])
                period[latch_ch][3:0] = b[3:0];
            else
                period[latch_ch][9:4] = b[5:0];
        end
        else begin
            prescale++;
            if (prescale >= TICKS_PER_STEP) begin
                prescale = 0;
                acc = 0;
                for (int ch = 0; ch < NUM_TONES; ch++) begin
                    if (period[ch] != '0) begin
                        counter[ch]--;
                        if (counter[ch] <= 0) begin
                            counter[ch]  = period[ch];
                            polarity[ch] = !polarity[ch];
                        end
                        acc += scaled(att_scale[atten[ch]], polarity[ch], gain[ch]);
                    end
                end
                if (noise_ctl != '0) begin
                    counter[CH_NOISE]--;
                    if (counter[CH_NOISE] <= 0) begin
                        case (psg_noise_rate_t'(noise_ctl[1:0]))
                            NOISE_RATE_16: counter[CH_NOISE] = NOISE_RELOAD_16;
                            NOISE_RATE_32: counter[CH_NOISE] = NOISE_RELOAD_32;
                            NOISE_RATE_64: counter[CH_NOISE] = NOISE_RELOAD_64;
                            default:       counter[CH_NOISE] = period[CH_TONE2];
                        endcase
                        polarity[CH_NOISE] = !polarity[CH_NOISE];
                        // shift only on the rising half of the noise square wave
                        if (!polarity[CH_NOISE])
                            lfsr = {noise_ctl[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0], lfsr[15:1]};
                    end
                    if (lfsr[0])
                        acc += scaled(att_scale[atten[CH_NOISE]], 1'b0, gain[CH_NOISE]);
                end
                samples_due.push_back(acc[SAMPLE_W-1:0]);
                steps_predicted++;
            end
        end
    endfunction

    task automatic send_req(input psg_op_t op, input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        predict(op, b);
        items_sent++;
    endtask

    task automatic ticks(input int n);
        repeat (n) send_req(OP_TICK, 8'($urandom));
    endtask

    // stop offering requests and let every pending sample come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (samples_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                              input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
        logic [GAIN_W-1:0] vals [NUM_CH];
        vals = '{g0, g1, g2, g3};
        for (int i = 0; i < NUM_CH; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            gain[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        logic [7:0] setup [11] = '{8'h8F, 8'h3F, 8'h90, 8'hA1, 8'h00, 8'hB0,
                                   8'hD0, 8'hC0, 8'h00, 8'hE7, 8'hF0};
        logic [7:0] rework [4] = '{8'hFF, 8'h0E, 8'hE0, 8'h45};
        // tone 0 at full period, tone 1 at period one, tone 2 off,
        // noise clocked by the zero tone 2 period; reset gains first
        foreach (setup[i])
            send_req(OP_WRITE, setup[i]);
        ticks(TICKS_PER_STEP);
        drain();
        load_gains(9'd0, GAIN_UNITY, 9'd511, 9'd257);
        ticks(TICKS_PER_STEP);
        // noise volume via data byte, noise control via data byte
        foreach (rework[i])
            send_req(OP_WRITE, rework[i]);
        ticks(TICKS_PER_STEP);
        drain();
    endtask

    task automatic test_backpressure();
        tx_calm     = 1'b1;
        hold_cycles = 250;
        ticks(6 * TICKS_PER_STEP);
        tx_calm = 1'b0;
        drain();
    endtask

    task automatic test_sender_pause();
        send_req(OP_WRITE, 8'h83);
        send_req(OP_WRITE, 8'h92);
        ticks(2 * TICKS_PER_STEP + 5);
        drain();
        ticks(TICKS_PER_STEP);
        drain();
    endtask

    task automatic test_random();
        int         first_item;
        int         first_step;
        logic [GAIN_W-1:0] pick [NUM_CH];
        logic [7:0] b;
        first_item = items_sent;
        first_step = steps_predicted;
        while (items_sent - first_item < RANDOM_ITEMS
               || steps_predicted - first_step < RANDOM_STEPS) begin
            drain();
            foreach (pick[i])
                pick[i] = ($urandom_range(0, 1) != 0) ? gain_edges[$urandom_range(0, 6)]
                                                      : GAIN_W'($urandom_range(0, 511));
            load_gains(pick[0], pick[1], pick[2], pick[3]);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(60, 160)) begin
                if ($urandom_range(0, 3) != 0)
                    send_req(OP_TICK, 8'($urandom));
                else begin
                    case ($urandom_range(0, 9))
                        0, 1:    b = {1'b1, 2'($urandom_range(0, 2)), 1'b0, 4'($urandom)};
                        // keep upper period bits mostly clear so tones actually toggle
                        2:       b = {1'b0, 1'($urandom),
                                      ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0};
                        3, 4:    b = {1'b1, 2'($urandom), 1'b1, 4'($urandom)};
                        5:       b = {1'b1, CH_NOISE, 1'b0, 4'($urandom)};
                        default: b = 8'($urandom);
                    endcase
                    send_req(OP_WRITE, b);
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
                stall = rx_calm ? 0 : $urandom_range(0, 17);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_samples
        logic [SAMPLE_W-1:0] want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected sample, expected none actual %0d", $time,
                         $signed(m_axis_tdata[SAMPLE_W-1:0]));
                errors++;
            end
            else begin
                want = samples_due.pop_front();
                if (m_axis_tdata[SAMPLE_W-1:0] !== want) begin
                    $display("%0t: sample mismatch, expected %0d actual %0d", $time,
                             $signed(want), $signed(m_axis_tdata[SAMPLE_W-1:0]));
                    errors++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:SAMPLE_W] !== '0) begin
                    $display("%0t: tdata padding mismatch, expected 0 actual %0h", $time,
                             m_axis_tdata[OUT_DATA_W-1:SAMPLE_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
